// ----- sv/utf8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Shared types, result codes and the lead byte class tables of the decoder.
// ----------------------------------------------------------------------------
package utf8u16_pkg;

   typedef enum logic [1:0] {
      KIND_UNIT      = 2'd0,
      KIND_INVALID   = 2'd1,
      KIND_RANGE     = 2'd2,
      KIND_TRUNCATED = 2'd3
   } kind_type;

   typedef struct packed {
      logic [15:0] code_unit;
      kind_type    kind;
      logic        last_of_run;
   } result_type;

   // Up to two results come out of one source byte.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_out_type;

   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_COUNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;
   localparam logic [20:0] PLANE1_BASE    = 21'h01_0000;
   localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;  // 0xD800 >> 10
   localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;  // 0xDC00 >> 10
   localparam logic [1:0]  TRAILER_TAG    = 2'b10;

   // Number of trailing bytes announced by a lead byte.
   function automatic logic [2:0] trailer_count(input logic [7:0] b);
      logic [2:0] t;
      if (b < 8'hC0)       t = 3'd0;
      else if (b < 8'hE0)  t = 3'd1;
      else if (b < 8'hF0)  t = 3'd2;
      else if (b < 8'hF8)  t = 3'd3;
      else if (b < 8'hFC)  t = 3'd4;
      else                 t = 3'd5;
      return t;
   endfunction

   function automatic logic [7:0] lead_mask(input logic [2:0] t);
      logic [7:0] m;
      unique case (t)
         3'd0:    m = 8'h80;
         3'd1:    m = 8'hE0;
         3'd2:    m = 8'hF0;
         3'd3:    m = 8'hF8;
         3'd4:    m = 8'hFC;
         3'd5:    m = 8'hFE;
         default: m = 8'hFF;
      endcase
      return m;
   endfunction

   function automatic logic [7:0] lead_marker(input logic [2:0] t);
      logic [7:0] m;
      unique case (t)
         3'd0:    m = 8'h00;
         3'd1:    m = 8'hC0;
         3'd2:    m = 8'hE0;
         3'd3:    m = 8'hF0;
         3'd4:    m = 8'hF8;
         3'd5:    m = 8'hFC;
         default: m = 8'hFF;
      endcase
      return m;
   endfunction

   // Sum of the marker bits folded into the accumulator for each length.
   function automatic logic [31:0] len_offset(input logic [2:0] t);
      logic [31:0] o;
      unique case (t)
         3'd1:    o = 32'h0000_3080;
         3'd2:    o = 32'h000E_2080;
         3'd3:    o = 32'h03C8_2080;
         3'd4:    o = 32'hFA08_2080;
         3'd5:    o = 32'h8208_2080;
         default: o = 32'h0000_0000;
      endcase
      return o;
   endfunction

endpackage

// ----- sv/utf8_to_utf16_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder unit
// Decodes a UTF-8 byte stream into UTF-16 code units and error reports.
//
//   channel  direction  payload
//   req      in         in_byte[7:0], end_of_stream
//   rsp      out        code_unit[15:0], kind[1:0], last_of_run
//
// One source byte is taken per cycle unless req stalls; its results pass the input
// register, then the result queue, before they can be taken on rsp.
// A byte that ends a surrogate pair pushes two results and the queue absorbs
// them, so with rsp_ready held high req takes a byte in every cycle.
// req stalls only while the queue has fewer than two free entries. Reset clears
// the sequence state, the input stage and the queue.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic [1:0]  rsp_kind,
   output logic        rsp_last_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;
   logic       room;
   logic       fire;
   logic       req_accept;

   utf8u16_pkg::step_out_type step_out;
   utf8u16_pkg::result_type   rsp_entry;

   assign fire        = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || fire;
   assign req_accept  = req_valid && req_ready;
   assign in_valid_in = req_accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_in_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   utf8u16_step u_step (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .in_byte       (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .step_out      (step_out)
   );

   utf8u16_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .step_out  (step_out),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_entry (rsp_entry)
   );

   assign rsp_code_unit   = rsp_entry.code_unit;
   assign rsp_kind        = rsp_entry.kind;
   assign rsp_last_of_run = rsp_entry.last_of_run;

endmodule

// ----- sv/utf8u16_step.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder step
// Holds the sequence state and decodes one registered source byte per fire.
// ----------------------------------------------------------------------------
module utf8u16_step (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [7:0]                 in_byte,
   input  logic                       end_of_stream,
   output utf8u16_pkg::step_out_type  step_out
);

   logic [31:0] accum_ff, accum_in;
   logic [2:0]  pending_ff, pending_in;
   logic [2:0]  trailers_ff, trailers_in;
   logic        error_ff, error_in;

   logic [2:0]  lead_t;
   logic [31:0] accum_next;
   logic [2:0]  pending_dec;
   logic [31:0] value;
   logic [20:0] plane_off;
   utf8u16_pkg::step_out_type res;

   assign lead_t      = utf8u16_pkg::trailer_count(in_byte);
   assign accum_next  = {accum_ff[25:0], 6'd0} + {24'd0, in_byte};
   assign pending_dec = pending_ff - 3'd1;
   assign value       = accum_next - utf8u16_pkg::len_offset(trailers_ff);
   assign plane_off   = value[20:0] - utf8u16_pkg::PLANE1_BASE;

   always_comb begin
      res          = '0;
      accum_in     = accum_ff;
      pending_in   = pending_ff;
      trailers_in  = trailers_ff;
      error_in     = error_ff;

      if (error_ff) begin
         // Bytes are dropped until the end of the stream.
      end else if (pending_ff == 3'd0) begin
         if (!in_byte[7]) begin
            res.count           = 2'd1;
            res.first.code_unit = {8'd0, in_byte};
            res.first.kind      = utf8u16_pkg::KIND_UNIT;
         end else if (end_of_stream && lead_t != 3'd0) begin
            res.count      = 2'd1;
            res.first.kind = utf8u16_pkg::KIND_TRUNCATED;
         end else if ((in_byte & utf8u16_pkg::lead_mask(lead_t))
                      != utf8u16_pkg::lead_marker(lead_t)) begin
            res.count      = 2'd1;
            res.first.kind = utf8u16_pkg::KIND_INVALID;
            error_in       = 1'b1;
         end else begin
            accum_in    = {24'd0, in_byte};
            pending_in  = lead_t;
            trailers_in = lead_t;
         end
      end else begin
         if (end_of_stream && pending_ff > 3'd1) begin
            res.count      = 2'd1;
            res.first.kind = utf8u16_pkg::KIND_TRUNCATED;
         end else if (in_byte[7:6] != utf8u16_pkg::TRAILER_TAG) begin
            res.count      = 2'd1;
            res.first.kind = utf8u16_pkg::KIND_INVALID;
            error_in       = 1'b1;
         end else begin
            accum_in   = accum_next;
            pending_in = pending_dec;
            if (pending_dec == 3'd0) begin
               if (value[31:16] == 16'd0) begin
                  res.count           = 2'd1;
                  res.first.code_unit = value[15:0];
                  res.first.kind      = utf8u16_pkg::KIND_UNIT;
               end else if (value > utf8u16_pkg::MAX_CODE_POINT) begin
                  res.count      = 2'd1;
                  res.first.kind = utf8u16_pkg::KIND_RANGE;
                  error_in       = 1'b1;
               end else begin
                  res.count            = 2'd2;
                  res.first.code_unit  = {utf8u16_pkg::HIGH_SURR_TAG, plane_off[19:10]};
                  res.first.kind       = utf8u16_pkg::KIND_UNIT;
                  res.second.code_unit = {utf8u16_pkg::LOW_SURR_TAG, plane_off[9:0]};
                  res.second.kind      = utf8u16_pkg::KIND_UNIT;
               end
               accum_in    = 32'd0;
               trailers_in = 3'd0;
            end
         end
      end

      if (res.count == 2'd1) res.first.last_of_run = 1'b1;
      if (res.count == 2'd2) res.second.last_of_run = 1'b1;

      if (end_of_stream) begin
         accum_in    = 32'd0;
         pending_in  = 3'd0;
         trailers_in = 3'd0;
         error_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= 32'd0;
         pending_ff  <= 3'd0;
         trailers_ff <= 3'd0;
         error_ff    <= 1'b0;
      end else if (fire) begin
         accum_ff    <= accum_in;
         pending_ff  <= pending_in;
         trailers_ff <= trailers_in;
         error_ff    <= error_in;
      end
   end

   assign step_out = res;

endmodule

// ----- sv/utf8u16_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder result queue
// Small queue that takes zero to two results per cycle and sends one per beat.
// ----------------------------------------------------------------------------
module utf8u16_rsp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  utf8u16_pkg::step_out_type  step_out,
   output logic                       room,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output utf8u16_pkg::result_type    rsp_entry
);

   localparam int PW = utf8u16_pkg::RSP_PTR_W;
   localparam int CW = utf8u16_pkg::RSP_COUNT_W;

   utf8u16_pkg::result_type mem_ff [utf8u16_pkg::RSP_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] wr_ptr_next;
   logic [CW-1:0] push_count;
   logic          pop;

   assign push_count  = push ? CW'(step_out.count) : CW'(0);
   assign pop         = rsp_valid && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + PW'(1);
   assign wr_ptr_in   = wr_ptr_ff + push_count[PW-1:0];
   assign rd_ptr_in   = rd_ptr_ff + PW'(pop);
   assign count_in    = count_ff + push_count - CW'(pop);

   // A byte may produce two results, so two free slots are needed to take one.
   assign room      = count_ff <= CW'(utf8u16_pkg::RSP_DEPTH - 2);
   assign rsp_valid = count_ff != CW'(0);
   assign rsp_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && step_out.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= step_out.first;
      end
      if (push && step_out.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= step_out.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
